FILE: rtl/bbd_pkg.sv
package bbd_pkg;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 16;
  localparam int OUT_COL_W    = 11;
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 16;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;
  localparam int DEF_MAX_LINE = 2048;

  localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RST  = CFG_WIDTH_W'(640);
  localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RST = CFG_HEIGHT_W'(480);

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // 3x3 neighborhood, [row][col], row 0 is the oldest line
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic [PIX_W-1:0] older;
    logic [PIX_W-1:0] middle;
  } line_pair_t;

  // per-pixel position data that travels alongside the window
  typedef struct packed {
    logic                 up;
    logic                 dn;
    logic                 lf;
    logic                 rt;
    logic                 row_odd;
    logic                 green_site;
    logic                 frame_end;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
  } pix_info_t;

  // Average of cnt samples rounded half up: (2*sum + cnt) / (2*cnt).
  // Divide by six is a multiply by 10923 / 2^16, exact for 2*sum+3 <= 1533.
  function automatic logic [PIX_W-1:0] avg_round(input logic [9:0] sum,
                                                 input logic [2:0] cnt);
    logic [10:0] x;
    logic [24:0] p;
    logic [PIX_W-1:0] res;
    x = {sum, 1'b0} + 11'd3;
    p = 25'(x) * 25'd10923;
    case (cnt)
      3'd1: res = sum[PIX_W-1:0];
      3'd2: res = 8'((11'(sum) + 11'd1) >> 1);
      3'd3: res = p[23:16];
      3'd4: res = 8'((11'(sum) + 11'd2) >> 2);
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/bbd_line_buffer.sv
module bbd_line_buffer #(
  parameter int MAX_LINE = bbd_pkg::DEF_MAX_LINE
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_LINE)-1:0]  rd_addr,
  output bbd_pkg::line_pair_t          rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_LINE)-1:0]  wr_addr,
  input  bbd_pkg::line_pair_t          wr_data
);
  import bbd_pkg::*;

  // both line stores share one address, so they live in one wide memory
  line_pair_t mem [MAX_LINE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/bbd_interp.sv
module bbd_interp (
  input  bbd_pkg::window_t            win,
  input  bbd_pkg::pix_info_t          info,
  output logic [bbd_pkg::PIX_W-1:0]   red,
  output logic [bbd_pkg::PIX_W-1:0]   green,
  output logic [bbd_pkg::PIX_W-1:0]   blue
);
  import bbd_pkg::*;

  logic [9:0]       sv, sh, sd;
  logic [2:0]       nv, nh, nd;
  logic [PIX_W-1:0] avg_v, avg_h, avg_4, avg_d;

  always_comb begin
    sv = '0; nv = '0;
    sh = '0; nh = '0;
    sd = '0; nd = '0;
    if (info.up) begin
      sv = sv + 10'(win[0][1]); nv = nv + 3'd1;
    end
    if (info.dn) begin
      sv = sv + 10'(win[2][1]); nv = nv + 3'd1;
    end
    if (info.lf) begin
      sh = sh + 10'(win[1][0]); nh = nh + 3'd1;
    end
    if (info.rt) begin
      sh = sh + 10'(win[1][2]); nh = nh + 3'd1;
    end
    if (info.up && info.lf) begin
      sd = sd + 10'(win[0][0]); nd = nd + 3'd1;
    end
    if (info.up && info.rt) begin
      sd = sd + 10'(win[0][2]); nd = nd + 3'd1;
    end
    if (info.dn && info.lf) begin
      sd = sd + 10'(win[2][0]); nd = nd + 3'd1;
    end
    if (info.dn && info.rt) begin
      sd = sd + 10'(win[2][2]); nd = nd + 3'd1;
    end

    avg_v = avg_round(sv, nv);
    avg_h = avg_round(sh, nh);
    avg_4 = avg_round(sv + sh, nv + nh);
    avg_d = avg_round(sd, nd);

    if (info.green_site) begin
      // green site: red and blue sit on opposite axes, swapped by row parity
      green = win[1][1];
      red   = info.row_odd ? avg_v : avg_h;
      blue  = info.row_odd ? avg_h : avg_v;
    end else begin
      green = avg_4;
      red   = info.row_odd ? avg_d : win[1][1];
      blue  = info.row_odd ? win[1][1] : avg_d;
    end
  end

endmodule

FILE: rtl/bbd_regs.sv
module bbd_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bbd_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [bbd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [bbd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [bbd_pkg::CFG_WIDTH_W-1:0]     frame_width,
  output logic [bbd_pkg::CFG_HEIGHT_W-1:0]    frame_height,
  output logic                                cfg_write
);
  import bbd_pkg::*;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: rtl/bayer_bilinear_demosaic.sv
// Bilinear demosaic for a GRBG Bayer stream. Raw 8-bit words enter in raster
// order on the pix channel (action 0); every word carries one full RGB pixel
// out on the rgb channel, with its row, column and a frame_end flag on the
// last pixel of the frame. Output lags input by one row plus one pixel, so
// after the last raw word of a frame send the clamped frame width + 1 drain words
// (action 1) to flush the tail; a drain word sent mid-frame is taken and
// dropped. Missing colors are the rounded-half-up average of the same-color
// neighbors that lie inside the frame. Throughput is one word per clock: a
// word is accepted, reads both line buffers from one memory read port,
// shifts into the 3x3 window and then lands in the output register;
// pix_ready drops only while the output register holds a result that the
// sink has not taken. The line buffers need no clearing pass: rows that
// were never written only feed neighbors outside the frame.
// frame_width (offset 0x0) is clamped to [2, MAX_LINE]; frame_height
// (offset 0x4) is raised to 2 if smaller. Write either register only while
// the block is idle; a write restarts the frame.
module bayer_bilinear_demosaic #(
  parameter int MAX_LINE = bbd_pkg::DEF_MAX_LINE
) (
  input  logic                               clk,
  input  logic                               rst,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bbd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bbd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bbd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  // raw pixel input
  input  logic                               pix_valid,
  output logic                               pix_ready,
  input  logic                               action,
  input  logic [bbd_pkg::PIX_W-1:0]          raw_value,
  // RGB output
  output logic                               rgb_valid,
  input  logic                               rgb_ready,
  output logic [bbd_pkg::PIX_W-1:0]          red,
  output logic [bbd_pkg::PIX_W-1:0]          green,
  output logic [bbd_pkg::PIX_W-1:0]          blue,
  output logic [bbd_pkg::ROW_W-1:0]          out_row,
  output logic [bbd_pkg::OUT_COL_W-1:0]      out_col,
  output logic                               frame_end
);
  import bbd_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE);
  // wide enough for the width register and for MAX_LINE itself
  localparam int WW    = ($clog2(MAX_LINE + 1) > CFG_WIDTH_W) ?
                         $clog2(MAX_LINE + 1) : CFG_WIDTH_W;
  // input row runs up to two rows past the last row while the tail drains
  localparam int RW    = ROW_W + 1;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  logic [CFG_WIDTH_W-1:0]  frame_width;
  logic [CFG_HEIGHT_W-1:0] frame_height;
  logic                    cfg_write;

  bbd_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .cfg_write    (cfg_write)
  );

  logic [WW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;

  always_comb begin
    if (frame_width < CFG_WIDTH_W'(2)) begin
      eff_w = WW'(2);
    end else if (WW'(frame_width) > WW'(MAX_LINE)) begin
      eff_w = WW'(MAX_LINE);
    end else begin
      eff_w = WW'(frame_width);
    end
    eff_h = (frame_height < ROW_W'(2)) ? ROW_W'(2) : ROW_W'(frame_height);
  end

  // ---------------------------------------------------------------------
  // input and output position counters, advanced by each accepted word that is not dropped
  // ---------------------------------------------------------------------
  logic [RW-1:0]    in_row, in_row_next;
  logic [COL_W-1:0] in_col, in_col_next;
  logic [ROW_W-1:0] emit_row, emit_row_next;
  logic [COL_W-1:0] emit_col, emit_col_next;

  logic accept, past_frame, step, emit;
  logic col_last, up, dn, lf, rt, frame_done;

  assign accept     = pix_valid && pix_ready;
  // once every raw word of the frame is in, any word acts as a drain word
  assign past_frame = in_row >= RW'(eff_h);
  assign step       = accept && (!action || past_frame);
  // the window is centered on a pixel once the row below has reached it
  assign emit       = (in_row >= RW'(2)) || (in_row == RW'(1) && in_col != '0);

  assign col_last   = ({1'b0, WW'(in_col)} + (WW+1)'(1)) >= {1'b0, eff_w};
  assign up         = emit_row != '0;
  assign dn         = ({1'b0, emit_row} + RW'(1)) < {1'b0, eff_h};
  assign lf         = emit_col != '0;
  assign rt         = ({1'b0, WW'(emit_col)} + (WW+1)'(1)) < {1'b0, eff_w};
  assign frame_done = emit && !dn && !rt;

  always_comb begin
    in_row_next   = in_row;
    in_col_next   = in_col;
    emit_row_next = emit_row;
    emit_col_next = emit_col;
    if (cfg_write || (step && frame_done)) begin
      // restart the frame
      in_row_next   = '0;
      in_col_next   = '0;
      emit_row_next = '0;
      emit_col_next = '0;
    end else if (step) begin
      if (col_last) begin
        in_col_next = '0;
        in_row_next = in_row + RW'(1);
      end else begin
        in_col_next = in_col + COL_W'(1);
      end
      if (emit) begin
        if (!rt) begin
          emit_col_next = '0;
          emit_row_next = emit_row + ROW_W'(1);
        end else begin
          emit_col_next = emit_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row   <= '0;
      in_col   <= '0;
      emit_row <= '0;
      emit_col <= '0;
    end else begin
      in_row   <= in_row_next;
      in_col   <= in_col_next;
      emit_row <= emit_row_next;
      emit_col <= emit_col_next;
    end
  end

  // ---------------------------------------------------------------------
  // pipeline control: stage 1 waits on line buffer data, stage 2 holds
  // the window, then the output register
  // ---------------------------------------------------------------------
  logic s1_valid, s1_emit;
  logic s2_valid;
  logic out_space, s2_done, s1_done, s1_adv;

  logic [COL_W-1:0] s1_col;
  logic [PIX_W-1:0] s1_v;
  pix_info_t        s1_info, s2_info;

  assign out_space = !rgb_valid || rgb_ready;
  assign s2_done   = !s2_valid || out_space;
  assign s1_adv    = s1_valid && s2_done;
  assign s1_done   = !s1_valid || s2_done;
  assign pix_ready = s1_done;

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (s1_done) begin
        s1_valid <= step;
      end
      if (s1_adv) begin
        s2_valid <= s1_emit;
      end else if (s2_done) begin
        s2_valid <= 1'b0;
      end
      if (out_space) begin
        rgb_valid <= s2_valid;
      end
    end
  end

  // stage 1 payload: hold the word and its output position
  always_ff @(posedge clk) begin
    if (s1_done && step) begin
      s1_col             <= in_col;
      s1_v               <= past_frame ? '0 : raw_value;
      s1_emit            <= emit;
      s1_info.up         <= up;
      s1_info.dn         <= dn;
      s1_info.lf         <= lf;
      s1_info.rt         <= rt;
      s1_info.row_odd    <= emit_row[0];
      s1_info.green_site <= ~(emit_row[0] ^ emit_col[0]);
      s1_info.frame_end  <= !dn && !rt;
      s1_info.row        <= emit_row;
      s1_info.col        <= OUT_COL_W'(emit_col);
    end
  end

  // ---------------------------------------------------------------------
  // line buffers: read both lines when a word steps in, write back when the word
  // advances into the window (the older line takes the old middle value)
  // ---------------------------------------------------------------------
  line_pair_t rd_data, wr_data;

  assign wr_data.older  = rd_data.middle;
  assign wr_data.middle = s1_v;

  bbd_line_buffer #(
    .MAX_LINE (MAX_LINE)
  ) u_lines (
    .clk     (clk),
    .rd_en   (step),
    .rd_addr (in_col),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  // ---------------------------------------------------------------------
  // 3x3 window: shift left, new column on the right
  // ---------------------------------------------------------------------
  window_t win;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_data.older;
      win[1][2] <= rd_data.middle;
      win[2][2] <= s1_v;
      s2_info   <= s1_info;
    end
  end

  // ---------------------------------------------------------------------
  // interpolation into the output register
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0] red_next, green_next, blue_next;

  bbd_interp u_interp (
    .win   (win),
    .info  (s2_info),
    .red   (red_next),
    .green (green_next),
    .blue  (blue_next)
  );

  always_ff @(posedge clk) begin
    if (out_space && s2_valid) begin
      red       <= red_next;
      green     <= green_next;
      blue      <= blue_next;
      out_row   <= s2_info.row;
      out_col   <= s2_info.col;
      frame_end <= s2_info.frame_end;
    end
  end

endmodule

FILE: sim/tb_bayer_bilinear_demosaic.sv
module tb_bayer_bilinear_demosaic;
  import bbd_pkg::*;

  // action codes of a raw word
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam int SETTLE       = 8;        // cycles to let the pipeline empty
  localparam int LONG_HOLD    = 500;      // long sink stall for the pressure phase
  localparam int RANDOM_WORDS = 1150;
  localparam int LIMIT        = 1000000;
  localparam int MAX_REPORTS  = 100;

  typedef struct {
    logic             act;
    logic [PIX_W-1:0] raw;
  } raw_word_t;

  typedef struct {
    logic [PIX_W-1:0]     r;
    logic [PIX_W-1:0]     g;
    logic [PIX_W-1:0]     b;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 fe;
  } rgb_word_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  pix_valid;
  logic                  pix_ready;
  logic                  action;
  logic [PIX_W-1:0]      raw_value;
  logic                  rgb_valid;
  logic                  rgb_ready;
  logic [PIX_W-1:0]      red;
  logic [PIX_W-1:0]      green;
  logic [PIX_W-1:0]      blue;
  logic [ROW_W-1:0]      out_row;
  logic [OUT_COL_W-1:0]  out_col;
  logic                  frame_end;

  bayer_bilinear_demosaic u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .action    (action),
    .raw_value (raw_value),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_row   (out_row),
    .out_col   (out_col),
    .frame_end (frame_end)
  );

  always #10 clk = ~clk;

  // Words waiting to be driven, and RGB words the demosaic model expects.
  raw_word_t raw_q[$];
  rgb_word_t rgb_expect_q[$];

  // Demosaic model state: register copies, line buffers, window, counters.
  logic [CFG_WIDTH_W-1:0]  cfg_width;
  logic [CFG_HEIGHT_W-1:0] cfg_height;
  logic [PIX_W-1:0]        line_old [DEF_MAX_LINE];
  logic [PIX_W-1:0]        line_mid [DEF_MAX_LINE];
  logic [PIX_W-1:0]        win [3][3];
  int unsigned             px_row, px_col, rgb_row, rgb_col;

  // Handshake bookkeeping and run statistics.
  bit          pix_took;
  bit          src_idle_en;
  bit          sink_idle_en;
  int          src_gap;
  int          sink_hold;
  int          hold_reqs;
  int          hold_acks;
  int          errors;
  int          planned;
  int          raw_accepted;
  int          rgb_checked;
  int          frame_ends;
  int          cycle_cnt;
  raw_word_t   cur;
  rgb_word_t   want;

  function automatic int unsigned active_width();
    if (cfg_width < 2) return 2;
    if (cfg_width > DEF_MAX_LINE) return DEF_MAX_LINE;
    return cfg_width;
  endfunction

  function automatic int unsigned active_height();
    return (cfg_height < 2) ? 2 : cfg_height;
  endfunction

  function automatic int unsigned mean_half_up(int unsigned sum, int unsigned cnt);
    if (cnt == 0) return 0;
    return (2 * sum + cnt) / (2 * cnt);
  endfunction

  // Restart the frame: clear the window and all position counters.
  function automatic void restart_frame();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win[i][j] = '0;
      end
    end
    px_row  = 0;
    px_col  = 0;
    rgb_row = 0;
    rgb_col = 0;
  endfunction

  // Advance the demosaic model by one accepted raw word; queue the RGB word it emits.
  task automatic demosaic_step(input logic act, input logic [PIX_W-1:0] raw);
    int unsigned w, h, c, er, ec, sv, nv, sh, nh, s, n, diag;
    logic [PIX_W-1:0] v;
    bit up, dn, lf, rt, emit;
    rgb_word_t x;
    w = active_width();
    h = active_height();
    // past the last pixel every word acts as a drain; before it a drain is dropped
    if (px_row >= h) begin
      v = '0;
    end else if (act == ACT_DRAIN) begin
      return;
    end else begin
      v = raw;
    end
    c = (px_col < DEF_MAX_LINE) ? px_col : DEF_MAX_LINE - 1;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = line_old[c];
    win[1][2] = line_mid[c];
    win[2][2] = v;
    line_old[c] = line_mid[c];
    line_mid[c] = v;
    emit = (px_row >= 2) || (px_row == 1 && px_col >= 1);
    px_col++;
    if (px_col >= w) begin
      px_col = 0;
      px_row++;
    end
    if (!emit) return;

    er = rgb_row;
    ec = rgb_col;
    up = er > 0;
    dn = er + 1 < h;
    lf = ec > 0;
    rt = ec + 1 < w;
    if (((er + ec) & 1) == 0) begin
      // green site: vertical pair and horizontal pair give red and blue
      sv = 0; nv = 0; sh = 0; nh = 0;
      if (up) begin sv += win[0][1]; nv++; end
      if (dn) begin sv += win[2][1]; nv++; end
      if (lf) begin sh += win[1][0]; nh++; end
      if (rt) begin sh += win[1][2]; nh++; end
      x.g = win[1][1];
      if ((er & 1) != 0) begin
        x.r = PIX_W'(mean_half_up(sv, nv));
        x.b = PIX_W'(mean_half_up(sh, nh));
      end else begin
        x.b = PIX_W'(mean_half_up(sv, nv));
        x.r = PIX_W'(mean_half_up(sh, nh));
      end
    end else begin
      // red or blue site: up, down, left and right neighbors give green, diagonals the other
      s = 0; n = 0;
      if (up) begin s += win[0][1]; n++; end
      if (dn) begin s += win[2][1]; n++; end
      if (lf) begin s += win[1][0]; n++; end
      if (rt) begin s += win[1][2]; n++; end
      x.g = PIX_W'(mean_half_up(s, n));
      s = 0; n = 0;
      if (up && lf) begin s += win[0][0]; n++; end
      if (up && rt) begin s += win[0][2]; n++; end
      if (dn && lf) begin s += win[2][0]; n++; end
      if (dn && rt) begin s += win[2][2]; n++; end
      diag = mean_half_up(s, n);
      if ((er & 1) != 0) begin
        x.b = win[1][1];
        x.r = PIX_W'(diag);
      end else begin
        x.r = win[1][1];
        x.b = PIX_W'(diag);
      end
    end
    x.row = ROW_W'(er);
    x.col = OUT_COL_W'(ec);
    x.fe  = 1'b0;
    rgb_col++;
    if (rgb_col >= w) begin
      rgb_col = 0;
      rgb_row++;
    end
    if (er + 1 >= h && ec + 1 >= w) begin
      x.fe = 1'b1;
      restart_frame();
    end
    rgb_expect_q.insert(rgb_expect_q.size(), x);
  endtask

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got);
    if (exp_v != got) begin
      errors++;
      // keep the log readable when the block is badly off
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got);
    end
  endfunction

  // Monitor: sample both handshakes at the rising edge, predict first, then check.
  always @(posedge clk) begin
    pix_took = !rst && pix_valid && pix_ready;
    if (pix_took) begin
      raw_accepted++;
      demosaic_step(action, raw_value);
    end
    if (!rst && rgb_valid && rgb_ready) begin
      if (rgb_expect_q.size() == 0) begin
        errors++;
        $display("%0t: RGB word at row %0d col %0d with nothing expected, expected none actual 1",
                 $time, out_row, out_col);
      end else begin
        want = rgb_expect_q.pop_front();
        check_field("red", want.r, red);
        check_field("green", want.g, green);
        check_field("blue", want.b, blue);
        check_field("out_row", want.row, out_row);
        check_field("out_col", want.col, out_col);
        check_field("frame_end", want.fe, frame_end);
        rgb_checked++;
        if (frame_end) frame_ends++;
      end
    end
  end

  // Driver: hold the word until taken, then advance to the next one or idle.
  always @(negedge clk) begin
    if (!rst && (!pix_valid || pix_took)) begin
      if (src_gap > 0) begin
        src_gap--;
        pix_valid <= 1'b0;
      end else if (raw_q.size() > 0) begin
        cur = raw_q.pop_front();
        action    <= cur.act;
        raw_value <= cur.raw;
        pix_valid <= 1'b1;
        if (src_idle_en && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 11);
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Sink: random stall bursts, plus one long hold on request.
  always @(negedge clk) begin
    if (hold_reqs != hold_acks) begin
      hold_acks++;
      sink_hold = LONG_HOLD;
    end
    if (rst) begin
      rgb_ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      rgb_ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
      sink_hold = $urandom_range(0, 10);
      rgb_ready <= 1'b0;
    end else begin
      rgb_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles, %0d RGB words still expected",
               LIMIT, rgb_expect_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_word(input logic act, input logic [PIX_W-1:0] raw);
    raw_word_t it;
    it.act = act;
    it.raw = raw;
    raw_q.insert(raw_q.size(), it);
  endtask

  // Write one register through the APB port, then restart the model frame.
  task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cfg_width = val[CFG_WIDTH_W-1:0];
    else cfg_height = val[CFG_HEIGHT_W-1:0];
    restart_frame();
  endtask

  // Wait until every word is taken and every RGB word is back, then let the pipe settle.
  task automatic wait_idle();
    while (raw_q.size() != 0 || pix_valid || rgb_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Queue npix raw pixels of a w x h frame with stray drains; flush it when complete.
  task automatic queue_frame(input int unsigned w, input int unsigned h,
                             input int unsigned npix);
    int unsigned flush;
    logic [PIX_W-1:0] val;
    for (int unsigned k = 0; k < npix; k++) begin
      if ($urandom_range(0, 19) == 0) push_word(ACT_DRAIN, PIX_W'($urandom));
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = '1;
        default: val = PIX_W'($urandom);
      endcase
      push_word(ACT_PIXEL, val);
      planned++;
    end
    if (npix == w * h) begin
      // mostly an exact flush; now and then a short or long one
      flush = w + 1;
      if ($urandom_range(0, 7) == 0) flush = $urandom_range(w, w + 3);
      for (int unsigned k = 0; k < flush; k++) begin
        push_word($urandom_range(0, 1) ? ACT_DRAIN : ACT_PIXEL, PIX_W'($urandom));
        planned++;
      end
    end
  endtask

  initial begin
    logic [APB_DATA_W-1:0] wval, hval;
    int unsigned w, h, nframes, phase;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    pix_valid = 1'b0;
    action    = ACT_PIXEL;
    raw_value = '0;
    rgb_ready = 1'b0;
    cfg_width  = FRAME_WIDTH_RST;
    cfg_height = FRAME_HEIGHT_RST;
    for (int i = 0; i < DEF_MAX_LINE; i++) begin
      line_old[i] = '0;
      line_mid[i] = '0;
    end
    restart_frame();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: 2x2 frame (width and height below range, clamped up), where every
    // site loses neighbors to the frame edge; extreme values, a drain mid-frame,
    // and a pixel sent after the last one that must act as a drain.
    write_reg(REG_FRAME_WIDTH, 32'hFFFF_F000);
    write_reg(REG_FRAME_HEIGHT, 32'h0000_0000);
    push_word(ACT_PIXEL, 8'hFF);
    push_word(ACT_PIXEL, 8'h00);
    push_word(ACT_DRAIN, 8'h5A);
    push_word(ACT_PIXEL, 8'h00);
    push_word(ACT_PIXEL, 8'hFF);
    push_word(ACT_DRAIN, 8'h00);
    push_word(ACT_PIXEL, 8'hA5);
    push_word(ACT_DRAIN, 8'hFF);
    wait_idle();

    // Directed: 3x3 frame, height written with junk in the upper bits.
    write_reg(REG_FRAME_WIDTH, 32'd3);
    write_reg(REG_FRAME_HEIGHT, 32'hABCD_0003);
    push_word(ACT_PIXEL, 8'h00);
    push_word(ACT_PIXEL, 8'hFF);
    push_word(ACT_PIXEL, 8'h55);
    push_word(ACT_PIXEL, 8'hAA);
    push_word(ACT_PIXEL, 8'hFF);
    push_word(ACT_PIXEL, 8'h00);
    push_word(ACT_PIXEL, 8'h01);
    push_word(ACT_PIXEL, 8'hFE);
    push_word(ACT_PIXEL, 8'h80);
    repeat (4) push_word(ACT_DRAIN, 8'h00);
    wait_idle();

    // Random phases: new geometry, a few frames, sometimes one cut short.
    planned = 0;
    phase = 0;
    while (planned < RANDOM_WORDS || phase <= 2) begin
      case ($urandom_range(0, 9))
        0:       wval = $urandom_range(0, 1);
        1:       wval = $urandom_range(11, 64);
        default: wval = $urandom_range(2, 10);
      endcase
      if ($urandom_range(0, 4) == 0) wval |= $urandom & 32'hFFFF_F000;
      hval = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      if ($urandom_range(0, 4) == 0) hval |= $urandom & 32'hFFFF_0000;
      if (phase == 2) begin
        wval = 40;
        hval = 6;
      end
      case ($urandom_range(0, 2))
        0: write_reg(REG_FRAME_WIDTH, wval);
        1: write_reg(REG_FRAME_HEIGHT, hval);
        default: begin
          write_reg(REG_FRAME_WIDTH, wval);
          write_reg(REG_FRAME_HEIGHT, hval);
        end
      endcase
      w = active_width();
      h = active_height();
      src_idle_en  = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;
      if (phase == 2) begin
        // back up the pipe: sender keeps offering while the sink holds off
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        queue_frame(w, h, w * h);
        hold_reqs++;
      end else begin
        nframes = $urandom_range(1, 3);
        for (int unsigned f = 0; f < nframes; f++) begin
          if (f + 1 == nframes && $urandom_range(0, 5) == 0)
            queue_frame(w, h, $urandom_range(1, w * h));
          else
            queue_frame(w, h, w * h);
        end
      end
      wait_idle();
      phase++;
    end

    // Last part, no idling: tallest frame (cut short) and a wide two-row frame.
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    write_reg(REG_FRAME_HEIGHT, 32'd65535);
    write_reg(REG_FRAME_WIDTH, 32'h0000_0FFF);
    write_reg(REG_FRAME_WIDTH, 32'd1);
    queue_frame(active_width(), active_height(), 120);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 32'd128);
    write_reg(REG_FRAME_HEIGHT, 32'h0001_0002);
    queue_frame(active_width(), active_height(), active_width() * active_height());
    wait_idle();

    $display("Checked %0d RGB words with %0d frame ends from %0d raw words accepted,",
             rgb_checked, frame_ends, raw_accepted);
    $display("over frames from 2x2 up to 128 wide and 65535 tall, with stalls and drains.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
